// ===== rtl/narp_pkg.sv =====
// ----------------------------------------------------------------------------
// Arpeggiator package
// Shared widths, event codes, register indexes and step orders for the
// note arpeggiator.
// ----------------------------------------------------------------------------
package narp_pkg;

	// Largest number of steps in a scale.
	localparam int MAX_STEPS = 8;

	// Width of an effective scale length (1..MAX_STEPS).
	localparam int LEN_W = $clog2(MAX_STEPS + 1);
	// Width of the step counter (0..MAX_STEPS-1).
	localparam int POS_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

	// Packed pitch table: eight entries of eight bits.
	localparam int PITCH_COUNT = 8;
	localparam int PITCH_W     = 8;

	// Field widths.
	localparam int OP_W       = 2;
	localparam int KEY_W      = 7;
	localparam int BEAT_W     = 8;
	localparam int TONE_OUT_W = 9;
	localparam int LENGTH_W   = 4;
	localparam int MODE_W     = 2;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = PITCH_COUNT * PITCH_W;

	typedef enum logic [OP_W-1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_BEAT    = 2'd2
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCALE_LENGTH  = 2'd0,
		REG_ORDER_MODE    = 2'd1,
		REG_SCALE_PITCHES = 2'd2
	} reg_index_t;

	typedef enum logic [MODE_W-1:0] {
		ORD_UP       = 2'd0,
		ORD_DOWN     = 2'd1,
		ORD_CONVERGE = 2'd2,
		ORD_DIVERGE  = 2'd3
	} order_t;

endpackage

// ===== rtl/narp_ifs.sv =====
// ----------------------------------------------------------------------------
// Arpeggiator channels
// Valid/ready channels for incoming events and outgoing notes.
// ----------------------------------------------------------------------------

interface narp_event_if;
	logic                        valid;
	logic                        ready;
	logic [narp_pkg::OP_W-1:0]   operation;
	logic [narp_pkg::KEY_W-1:0]  key_tone;
	logic [narp_pkg::KEY_W-1:0]  key_pressure;
	logic [narp_pkg::BEAT_W-1:0] beat_number;

	modport source (output valid, operation, key_tone, key_pressure, beat_number,
		input ready);
	modport sink (input valid, operation, key_tone, key_pressure, beat_number,
		output ready);
endinterface

interface narp_note_if;
	logic                            valid;
	logic                            ready;
	logic [narp_pkg::TONE_OUT_W-1:0] note_tone;
	logic [narp_pkg::KEY_W-1:0]      note_pressure;

	modport source (output valid, note_tone, note_pressure, input ready);
	modport sink (input valid, note_tone, note_pressure, output ready);
endinterface

// ===== rtl/note_arpeggiator_core.sv =====
// ----------------------------------------------------------------------------
// Note arpeggiator core
// One-key arpeggiator: press, release and beat events in, notes out.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake      Payload
//   evt      in   valid/ready    operation, key_tone, key_pressure, beat_number
//   note     out  valid/ready    note_tone, note_pressure
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// An event is taken into an input register, worked on in the following cycle
// and, if it is a beat that makes a note, the note is then loaded into the output
// register. A new event can be taken in every cycle, so the block sustains one
// item per cycle while it does not stall.
// The only stall is a full output register that the sink is not taking: then a
// beat that makes a note waits in the input register; press, release and quiet
// beats still move on. Reset clears key state, step counter and all valid flags
// and sets length one, order up, zero pitches at once; there is no clearing pass.
//
module note_arpeggiator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	narp_event_if.sink                          evt,
	narp_note_if.source                         note,
	input  logic                                cfg_we,
	input  logic [narp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [narp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int LenW = narp_pkg::LEN_W;
	localparam int PosW = narp_pkg::POS_W;

	// Configuration registers.
	logic [narp_pkg::LENGTH_W-1:0]   scale_length_q;
	narp_pkg::order_t                order_mode_q;
	logic [narp_pkg::CFG_DATA_W-1:0] scale_pitches_q;

	// Key state.
	logic                         armed_q;
	logic [narp_pkg::KEY_W-1:0]   held_tone_q;
	logic [narp_pkg::KEY_W-1:0]   held_pressure_q;
	logic [PosW-1:0]              step_q;

	// Input register.
	logic                         valid_s1;
	logic [narp_pkg::OP_W-1:0]    op_s1;
	logic [narp_pkg::KEY_W-1:0]   tone_s1;
	logic [narp_pkg::KEY_W-1:0]   pressure_s1;
	logic [narp_pkg::BEAT_W-1:0]  beat_s1;

	// Output register.
	logic                              note_valid_q;
	logic [narp_pkg::TONE_OUT_W-1:0]   note_tone_q;
	logic [narp_pkg::KEY_W-1:0]        note_pressure_q;

	logic                              beat_hit;
	logic                              out_free;
	logic                              advance_s1;
	logic                              load_note;
	logic [narp_pkg::LENGTH_W:0]       len_ext;
	logic [LenW-1:0]                   n_eff;
	logic [LenW-1:0]                   pos;
	logic [LenW-1:0]                   pos_next;
	logic [LenW-1:0]                   k;
	logic [2:0]                        k_lo;
	logic [narp_pkg::PITCH_W-1:0]      pitch;
	logic [narp_pkg::TONE_OUT_W-1:0]   tone_sum;

	// Converge order visits 0, n-1, 1, n-2, and so on.
	function automatic logic [LenW-1:0] converge_at(input logic [LenW-1:0] x,
		input logic [LenW-1:0] n);
		logic [LenW-1:0] half;
		half = x >> 1;
		return x[0] ? (n - LenW'(1) - half) : half;
	endfunction

	// A length of zero acts as one, anything above the maximum as the maximum.
	assign len_ext = {1'b0, scale_length_q};
	always_comb begin
		priority if (len_ext == '0) begin
			n_eff = LenW'(1);
		end else if (int'(len_ext) > narp_pkg::MAX_STEPS) begin
			n_eff = LenW'(narp_pkg::MAX_STEPS);
		end else begin
			n_eff = LenW'(len_ext);
		end
	end

	// The step counter always stays below the effective length, since a length
	// write clears it and it wraps at the length.
	assign pos      = LenW'(step_q);
	assign pos_next = (pos + LenW'(1) == n_eff) ? '0 : pos + LenW'(1);

	always_comb begin
		unique case (order_mode_q)
			narp_pkg::ORD_UP:       k = pos;
			narp_pkg::ORD_DOWN:     k = n_eff - LenW'(1) - pos;
			narp_pkg::ORD_CONVERGE: k = converge_at(pos, n_eff);
			narp_pkg::ORD_DIVERGE:  k = converge_at(n_eff - LenW'(1) - pos, n_eff);
			default:                k = pos;
		endcase
	end

	// Positions past the packed table read an offset of zero.
	assign k_lo  = 3'(k);
	assign pitch = (int'(k) < narp_pkg::PITCH_COUNT)
		? scale_pitches_q[{k_lo, 3'b000} +: narp_pkg::PITCH_W] : '0;
	assign tone_sum = narp_pkg::TONE_OUT_W'(held_tone_q)
		+ narp_pkg::TONE_OUT_W'(pitch);

	// Only a beat numbered zero while armed makes a note; that one needs room
	// in the output register, every other event passes straight through.
	assign beat_hit = valid_s1 && (op_s1 == narp_pkg::OP_BEAT) && armed_q
		&& (beat_s1 == '0);
	assign out_free   = !note_valid_q || note.ready;
	assign advance_s1 = valid_s1 && (!beat_hit || out_free);
	assign load_note  = advance_s1 && beat_hit;
	assign evt.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1       <= evt.operation;
			tone_s1     <= evt.key_tone;
			pressure_s1 <= evt.key_pressure;
			beat_s1     <= evt.beat_number;
		end
	end

	// Key state and configuration. A length write clears the step counter; it
	// comes last so that it wins over a step in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q         <= 1'b0;
			held_tone_q     <= '0;
			held_pressure_q <= '0;
			step_q          <= '0;
			scale_length_q  <= narp_pkg::LENGTH_W'(1);
			order_mode_q    <= narp_pkg::ORD_UP;
			scale_pitches_q <= '0;
		end else begin
			if (advance_s1) begin
				unique case (op_s1)
					narp_pkg::OP_PRESS: begin
						held_tone_q     <= tone_s1;
						held_pressure_q <= pressure_s1;
						armed_q         <= 1'b1;
					end
					narp_pkg::OP_RELEASE: begin
						armed_q <= 1'b0;
					end
					narp_pkg::OP_BEAT: begin
						if (beat_hit) begin
							step_q <= PosW'(pos_next);
						end
					end
					default: begin
					end
				endcase
			end
			if (cfg_we) begin
				unique case (cfg_index)
					narp_pkg::REG_SCALE_LENGTH: begin
						scale_length_q <= cfg_data[narp_pkg::LENGTH_W-1:0];
						step_q         <= '0;
					end
					narp_pkg::REG_ORDER_MODE: begin
						order_mode_q <= narp_pkg::order_t'(cfg_data[narp_pkg::MODE_W-1:0]);
					end
					narp_pkg::REG_SCALE_PITCHES: begin
						scale_pitches_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_valid_q <= 1'b0;
		end else if (load_note) begin
			note_valid_q <= 1'b1;
		end else if (note.ready) begin
			note_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_note) begin
			note_tone_q     <= tone_sum;
			note_pressure_q <= held_pressure_q;
		end
	end

	assign note.valid         = note_valid_q;
	assign note.note_tone     = note_tone_q;
	assign note.note_pressure = note_pressure_q;

`ifndef ASSERT_OFF
	// The step counter never reaches the effective length.
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		LenW'(step_q) < n_eff)
		else $error("step counter at or beyond the scale length");

	// A length write leaves the step counter at zero.
	a_length_clears_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == narp_pkg::REG_SCALE_LENGTH) |=> (step_q == '0))
		else $error("step counter not cleared by a length write");

	// A note is only made while a key is held.
	a_note_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		load_note |-> armed_q)
		else $error("note made while disarmed");
`endif

endmodule

// ===== sim/tb_note_arpeggiator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Note arpeggiator core testbench
// Sends press, release and beat events and rewrites the scale registers
// between phases. A scoreboard object keeps its own copy of the key state,
// the step counter and the registers. It builds the note that each beat should
// make and checks every note that leaves the block against that list, in order.
// ----------------------------------------------------------------------------
module tb_note_arpeggiator_core;

	// Codes that the package does not name: the spare event code and the spare
	// register index. The block must ignore both.
	localparam logic [narp_pkg::OP_W-1:0]        OP_UNUSED  = 2'd3;
	localparam logic [narp_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	// Each random phase uses this many items and this length, but every third
	// phase keeps the old one. Zero and values above MAX_STEPS test both clamps.
	localparam int PHASE_COUNT = 12;
	localparam int PHASE_ITEMS = 120;
	localparam int LENGTH_PLAN [PHASE_COUNT] = '{8, 1, 3, 0, 15, 5, 9, 2, 7, 4, 6, 8};

	// One note as it leaves the block.
	typedef struct packed {
		logic [narp_pkg::TONE_OUT_W-1:0] tone;
		logic [narp_pkg::KEY_W-1:0]      pressure;
	} note_t;

	// ------------------------------------------------------------------------
	// Scoreboard. It holds a mirror of the arpeggiator state and configuration.
	// It also holds the list of notes that the block still owes.
	// ------------------------------------------------------------------------
	class note_scoreboard;
		bit                            armed;
		bit [narp_pkg::KEY_W-1:0]      held_tone;
		bit [narp_pkg::KEY_W-1:0]      held_pressure;
		bit [narp_pkg::POS_W-1:0]      step;
		bit [narp_pkg::LENGTH_W-1:0]   length_reg;
		narp_pkg::order_t              order;
		bit [narp_pkg::CFG_DATA_W-1:0] pitches;
		note_t                         expected_notes[$];
		int                            errors;

		function new();
			armed         = 1'b0;
			held_tone     = '0;
			held_pressure = '0;
			step          = '0;
			length_reg    = narp_pkg::LENGTH_W'(1);
			order         = narp_pkg::ORD_UP;
			pitches       = '0;
			errors        = 0;
		endfunction

		// Converge order walks 0, n-1, 1, n-2, ... from the outside inward.
		function int unsigned converge(int unsigned i, int unsigned n);
			if (i % 2 == 0)
				return i / 2;
			return n - 1 - i / 2;
		endfunction

		function int unsigned pitch_slot(int unsigned i, int unsigned n);
			unique case (order)
				narp_pkg::ORD_UP:       return i;
				narp_pkg::ORD_DOWN:     return n - 1 - i;
				narp_pkg::ORD_CONVERGE: return converge(i, n);
				default:                return converge(n - 1 - i, n);
			endcase
		endfunction

		function void write_register(logic [narp_pkg::CFG_INDEX_W-1:0] idx,
				logic [narp_pkg::CFG_DATA_W-1:0] data);
			unique case (idx)
				narp_pkg::REG_SCALE_LENGTH: begin
					length_reg = data[narp_pkg::LENGTH_W-1:0];
					step = '0;
				end
				narp_pkg::REG_ORDER_MODE:
					order = narp_pkg::order_t'(data[narp_pkg::MODE_W-1:0]);
				narp_pkg::REG_SCALE_PITCHES: pitches = data;
				default: ;
			endcase
		endfunction

		// Update the state for one accepted event, and queue the note that it makes.
		function void take_event(logic [narp_pkg::OP_W-1:0] op,
				logic [narp_pkg::KEY_W-1:0] tone, logic [narp_pkg::KEY_W-1:0] pressure,
				logic [narp_pkg::BEAT_W-1:0] beat);
			int unsigned n;
			int unsigned i;
			int unsigned slot;
			bit [narp_pkg::PITCH_W-1:0] offset;
			note_t made;
			unique case (op)
				narp_pkg::OP_PRESS: begin
					held_tone = tone;
					held_pressure = pressure;
					armed = 1'b1;
				end
				narp_pkg::OP_RELEASE: armed = 1'b0;
				narp_pkg::OP_BEAT: begin
					if (armed && beat == '0) begin
						n = (length_reg == 0) ? 1 : length_reg;
						if (n > narp_pkg::MAX_STEPS)
							n = narp_pkg::MAX_STEPS;
						i = step % n;
						slot = pitch_slot(i, n);
						offset = (slot >= narp_pkg::PITCH_COUNT) ? '0
							: pitches[slot*narp_pkg::PITCH_W +: narp_pkg::PITCH_W];
						made.tone = narp_pkg::TONE_OUT_W'(held_tone)
							+ narp_pkg::TONE_OUT_W'(offset);
						made.pressure = held_pressure;
						expected_notes.push_back(made);
						step = narp_pkg::POS_W'((i + 1) % n);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_note(logic [narp_pkg::TONE_OUT_W-1:0] tone,
				logic [narp_pkg::KEY_W-1:0] pressure);
			note_t want;
			if (expected_notes.size() == 0) begin
				$display("%0t: note with none expected: tone %0d pressure %0d",
					$time, tone, pressure);
				errors++;
				return;
			end
			want = expected_notes.pop_front();
			if (tone !== want.tone) begin
				$display("%0t: note_tone expected %0d, actual %0d", $time, want.tone, tone);
				errors++;
			end
			if (pressure !== want.pressure) begin
				$display("%0t: note_pressure expected %0d, actual %0d",
					$time, want.pressure, pressure);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, channels and the block
	// ------------------------------------------------------------------------
	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [narp_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [narp_pkg::CFG_DATA_W-1:0]  cfg_data;

	narp_event_if evt_ch();
	narp_note_if  note_ch();

	note_scoreboard sb;

	// The current idle profile. It gives the chance, in percent, that the sender
	// skips a cycle and that the receiver stalls in a cycle.
	int send_idle_pct;
	int recv_stall_pct;
	// The main flow sets this to ask for one long stall of the receiver.
	// The receiver process counts the stall down by itself.
	int hold_request;
	int hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	note_arpeggiator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.note      (note_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The receiver. Ready changes only at the falling edge. During a long hold it
	// stays low the whole time. While the output register is full, the block
	// must push back on the event channel as soon as a beat that makes a note
	// is waiting.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			note_ch.ready <= 1'b0;
		end else begin
			note_ch.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
		end
	end

	// The monitor. It samples at the rising edge, the edge where writes and
	// handshakes happen. Inputs only change at the falling edge, so these values
	// are stable here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_register(cfg_index, cfg_data);
			if (evt_ch.valid && evt_ch.ready)
				sb.take_event(evt_ch.operation, evt_ch.key_tone, evt_ch.key_pressure,
					evt_ch.beat_number);
			if (note_ch.valid && note_ch.ready)
				sb.check_note(note_ch.note_tone, note_ch.note_pressure);
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offer one event. Before it, the sender may idle for some cycles. The task
	// returns at the rising edge where the block takes the event. Valid stays high
	// into the next call, so back-to-back events need no gap between them.
	task automatic send_item(input logic [narp_pkg::OP_W-1:0] op,
			input logic [narp_pkg::KEY_W-1:0] tone,
			input logic [narp_pkg::KEY_W-1:0] pressure,
			input logic [narp_pkg::BEAT_W-1:0] beat);
		@(negedge clk);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid        <= 1'b1;
		evt_ch.operation    <= op;
		evt_ch.key_tone     <= tone;
		evt_ch.key_pressure <= pressure;
		evt_ch.beat_number  <= beat;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
	endtask

	// A random event. Most events are beat zero, so that a held key plays long
	// runs of notes. Presses come often enough to keep the block armed, and
	// releases, quiet beats and the spare code make up the rest. Fields that the
	// operation does not use still carry random values.
	task automatic send_random_item();
		int r;
		logic [narp_pkg::OP_W-1:0] op;
		logic [narp_pkg::BEAT_W-1:0] beat;
		r = int'($urandom_range(99));
		beat = narp_pkg::BEAT_W'($urandom_range(255));
		if (r < 8) begin
			op = narp_pkg::OP_PRESS;
		end else if (r < 14) begin
			op = narp_pkg::OP_RELEASE;
		end else if (r < 18) begin
			op = OP_UNUSED;
		end else begin
			op = narp_pkg::OP_BEAT;
			beat = (r < 30) ? narp_pkg::BEAT_W'($urandom_range(255, 1)) : '0;
		end
		send_item(op, narp_pkg::KEY_W'($urandom_range(127)),
			narp_pkg::KEY_W'($urandom_range(127)), beat);
	endtask

	// Stop offering events. Then wait until every owed note has arrived, plus
	// a few cycles. A press or a quiet beat makes no note, so it can still be in
	// the block's two-stage pipe when the last note has come out.
	task automatic wait_notes_drained();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (sb.expected_notes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [narp_pkg::CFG_INDEX_W-1:0] idx,
			input logic [narp_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// The idle profiles in turn: none, sender idle, receiver stalling, both.
	task automatic set_profile(input int p);
		unique case (p)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 76;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 76;
			end
			default: begin
				send_idle_pct = 35;
				recv_stall_pct = 35;
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Main flow
	// ------------------------------------------------------------------------
	initial begin
		logic [narp_pkg::CFG_DATA_W-1:0] word;
		int sec;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		evt_ch.valid        = 1'b0;
		evt_ch.operation    = narp_pkg::OP_PRESS;
		evt_ch.key_tone     = '0;
		evt_ch.key_pressure = '0;
		evt_ch.beat_number  = '0;
		note_ch.ready       = 1'b0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		hold_request        = 0;
		hold_left           = 0;
		sb = new();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed events on the reset settings: a length of one, order up and
		// all pitch offsets zero.
		// A beat before any press must stay quiet.
		send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd0);
		// A release ignores its key fields, and the spare code is ignored entirely.
		send_item(narp_pkg::OP_RELEASE, 7'd127, 7'd127, 8'd255);
		send_item(OP_UNUSED, 7'd127, 7'd127, 8'd0);
		send_item(narp_pkg::OP_PRESS, 7'd127, 7'd127, 8'd0);
		send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd0);
		// Only beat zero plays a note.
		send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd255);
		send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd1);
		// A press while armed replaces the key and keeps the counter.
		send_item(narp_pkg::OP_PRESS, 7'd0, 7'd0, 8'd255);
		send_item(narp_pkg::OP_BEAT, 7'd127, 7'd127, 8'd0);
		send_item(narp_pkg::OP_RELEASE, 7'd0, 7'd0, 8'd0);
		send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd0);
		wait_notes_drained();

		// Largest offsets on the highest key: the note tone reaches its top value.
		write_reg(narp_pkg::REG_SCALE_PITCHES, '1);
		write_reg(narp_pkg::REG_SCALE_LENGTH, narp_pkg::CFG_DATA_W'(8));
		send_item(narp_pkg::OP_PRESS, 7'd127, 7'd127, 8'd0);
		send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd0);
		wait_notes_drained();

		// The offsets name their own slots, so each note shows which slot was read.
		// A length of fifteen is clamped to MAX_STEPS.
		write_reg(narp_pkg::REG_SCALE_PITCHES, 64'h0706_0504_0302_0100);
		write_reg(narp_pkg::REG_ORDER_MODE, narp_pkg::CFG_DATA_W'(narp_pkg::ORD_DOWN));
		write_reg(narp_pkg::REG_SCALE_LENGTH, narp_pkg::CFG_DATA_W'(15));
		send_item(narp_pkg::OP_PRESS, 7'd10, 7'd64, 8'd0);
		repeat (4) send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd0);
		wait_notes_drained();

		// A length of zero acts as one. A write to the spare register index must
		// change nothing.
		write_reg(narp_pkg::REG_SCALE_LENGTH, '0);
		write_reg(narp_pkg::REG_ORDER_MODE,
			narp_pkg::CFG_DATA_W'(narp_pkg::ORD_CONVERGE));
		write_reg(REG_UNUSED, '1);
		repeat (2) send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd0);
		wait_notes_drained();

		write_reg(narp_pkg::REG_SCALE_LENGTH, narp_pkg::CFG_DATA_W'(5));
		write_reg(narp_pkg::REG_ORDER_MODE,
			narp_pkg::CFG_DATA_W'(narp_pkg::ORD_DIVERGE));
		repeat (5) send_item(narp_pkg::OP_BEAT, 7'd0, 7'd0, 8'd0);
		wait_notes_drained();

		// Random phases. Each phase uses a new idle profile and new settings.
		// Every third phase leaves the length register alone, so the step counter
		// carries over across the change of order or pitches. Register writes
		// carry random upper bits, which the block must ignore.
		for (sec = 0; sec < PHASE_COUNT; sec++) begin
			set_profile(sec % 4);
			if (sec % 3 != 2) begin
				word = {$urandom, $urandom};
				word[narp_pkg::LENGTH_W-1:0] = narp_pkg::LENGTH_W'(LENGTH_PLAN[sec]);
				write_reg(narp_pkg::REG_SCALE_LENGTH, word);
			end
			word = {$urandom, $urandom};
			word[narp_pkg::MODE_W-1:0] = narp_pkg::MODE_W'((sec + sec / 4) % 4);
			write_reg(narp_pkg::REG_ORDER_MODE, word);
			if (sec == 5)
				word = '1;
			else if (sec == 9)
				word = '0;
			else
				word = {$urandom, $urandom};
			write_reg(narp_pkg::REG_SCALE_PITCHES, word);
			// One long receiver stall while the sender keeps pushing. The block fills up,
			// and then it has to stall the event channel.
			if (sec == 4)
				hold_request = 300;
			repeat (PHASE_ITEMS) send_random_item();
			wait_notes_drained();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_notes.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog. A correct run takes a small fraction of this time.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/narp_pkg.sv
rtl/narp_ifs.sv
rtl/note_arpeggiator_core.sv
sim/tb_note_arpeggiator_core.sv
